>>> hdl/arpc_pkg.sv
package arpc_pkg;

    // cache geometry
    localparam int CACHE_ENTRIES = 16;

    // field widths
    localparam int IP_W   = 32;
    localparam int MAC_W  = 48;
    localparam int KIND_W = 3;
    localparam int CFG_IDX_W = 8;

    // packet checks
    localparam logic [15:0] MIN_PKT_LEN = 16'd28;
    localparam logic [15:0] HW_ETHER    = 16'd1;
    localparam logic [15:0] PROTO_IPV4  = 16'h0800;
    localparam logic [7:0]  HW_ADDR_LEN = 8'd6;
    localparam logic [7:0]  IP_ADDR_LEN = 8'd4;
    localparam logic [15:0] OP_REQUEST  = 16'd1;

    localparam logic [IP_W-1:0]  IP_ALL_ONES  = {IP_W{1'b1}};
    localparam logic [MAC_W-1:0] MAC_ALL_ONES = {MAC_W{1'b1}};

    // command codes
    localparam logic CMD_PACKET  = 1'b0;
    localparam logic CMD_RESOLVE = 1'b1;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_DROP    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_LEARN   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_REPLY   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_RESOLVE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_MISS    = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OWN_IP  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_MAC = 8'd1;

    // token modes along the chain
    typedef logic [1:0] t_mode;
    localparam t_mode MODE_LOOKUP = 2'd0;
    localparam t_mode MODE_LEARN  = 2'd1;
    localparam t_mode MODE_FILL   = 2'd2;

    // token handed from cell to cell
    typedef struct packed {
        logic             vld;
        t_mode            mode;
        logic             done;
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
    } t_tok;

endpackage

>>> hdl/arpc_cell.sv
module arpc_cell
    import arpc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_tok i_tok,
    output t_tok o_tok
);

    logic             r_valid, n_valid;
    logic [IP_W-1:0]  r_ip, n_ip;
    logic [MAC_W-1:0] r_mac, n_mac;
    t_tok             r_tok, n_tok;
    logic             hit;

    // entry match against the passing token
    assign hit = r_valid && (r_ip == i_tok.ip);

    // lookup, update, fill of this entry
    always_comb begin
        n_tok   = i_tok;
        n_valid = r_valid;
        n_ip    = r_ip;
        n_mac   = r_mac;
        if (i_tok.vld && !i_tok.done) begin
            case (i_tok.mode)
                MODE_LOOKUP: begin
                    if (hit) begin
                        n_tok.done = 1'b1;
                        n_tok.mac  = r_mac;
                    end
                end
                MODE_LEARN: begin
                    // valid entries form a prefix, so the first free cell
                    // is reached only after every valid one has missed
                    if (hit) begin
                        n_mac      = i_tok.mac;
                        n_tok.done = 1'b1;
                    end else if (!r_valid) begin
                        n_ip       = i_tok.ip;
                        n_mac      = i_tok.mac;
                        n_valid    = 1'b1;
                        n_tok.done = 1'b1;
                    end
                end
                MODE_FILL: begin
                    // full cache: first cell takes the pair
                    n_ip       = i_tok.ip;
                    n_mac      = i_tok.mac;
                    n_valid    = 1'b1;
                    n_tok.done = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_tok.vld <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_tok   <= n_tok;
        end
    end

    // entry payload
    always_ff @(posedge i_clk) begin
        r_ip  <= n_ip;
        r_mac <= n_mac;
    end

    assign o_tok = r_tok;

endmodule

>>> hdl/arp_cache_and_responder.sv
// dropped packet, broadcast or own-address query: result in the cycle after accept
// cache walk (learn or lookup): accept loads the launch register, the token then passes
// through every cell register, one cell per cycle, then the result register follows
// learn into a full cache: the tail token is relaunched as a fill for a second walk;
// one item at a time, the next one is accepted at the edge that ends the result beat; no receiver stall
// reset (synchronous, active low) clears all entry valid marks, own_ip and own_mac at once
module arp_cache_and_responder
    import arpc_pkg::*;
#(
    parameter int ENTRIES = CACHE_ENTRIES
)
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_cmd,
    input  logic [15:0]          i_pkt_len,
    input  logic [15:0]          i_hw_type,
    input  logic [15:0]          i_proto_type,
    input  logic [7:0]           i_hw_len,
    input  logic [7:0]           i_proto_len,
    input  logic [15:0]          i_opcode,
    input  logic [MAC_W-1:0]     i_sender_mac,
    input  logic [IP_W-1:0]      i_sender_ip,
    input  logic [IP_W-1:0]      i_tgt_ip,
    input  logic [IP_W-1:0]      i_query_ip,
    output logic                 o_result_strobe,
    output logic [KIND_W-1:0]    o_result_kind,
    output logic [MAC_W-1:0]     o_result_mac,
    output logic [IP_W-1:0]      o_result_ip,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [MAC_W-1:0]     i_cfg_data
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_WALK = 1'b1;

    logic             r_state, n_state;
    logic             r_strobe, n_strobe;
    logic [KIND_W-1:0] r_kind, n_kind;
    logic [MAC_W-1:0] r_mac, n_mac;
    logic [IP_W-1:0]  r_ip, n_ip;
    logic [KIND_W-1:0] r_pend_kind, n_pend_kind;
    logic [MAC_W-1:0] r_pend_mac, n_pend_mac;
    logic [IP_W-1:0]  r_pend_ip, n_pend_ip;
    logic [IP_W-1:0]  r_own_ip;
    logic [MAC_W-1:0] r_own_mac;
    t_tok             r_launch, n_launch;
    t_tok             w_tok [ENTRIES+1];
    t_tok             tail;
    logic             accept;
    logic             pkt_ok;

    assign busy        = (r_state != S_IDLE);
    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;

    // header checks on a received packet
    assign pkt_ok = (i_pkt_len >= MIN_PKT_LEN) && (i_hw_type == HW_ETHER) &&
                    (i_proto_type == PROTO_IPV4) && (i_hw_len == HW_ADDR_LEN) &&
                    (i_proto_len == IP_ADDR_LEN);

    // row of cache cells
    assign w_tok[0] = r_launch;
    assign tail     = w_tok[ENTRIES];

    for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
        arpc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (w_tok[k]),
            .o_tok   (w_tok[k+1])
        );
    end

    // item sequencing
    always_comb begin
        n_state     = r_state;
        n_strobe    = 1'b0;
        n_kind      = r_kind;
        n_mac       = r_mac;
        n_ip        = r_ip;
        n_pend_kind = r_pend_kind;
        n_pend_mac  = r_pend_mac;
        n_pend_ip   = r_pend_ip;
        n_launch    = r_launch;
        n_launch.vld = 1'b0;
        if (accept) begin
            if (i_cmd == CMD_PACKET) begin
                if (pkt_ok) begin
                    n_launch = '{vld: 1'b1, mode: MODE_LEARN, done: 1'b0,
                                 ip: i_sender_ip, mac: i_sender_mac};
                    n_state  = S_WALK;
                    if ((i_opcode == OP_REQUEST) && (i_tgt_ip == r_own_ip)) begin
                        n_pend_kind = KIND_REPLY;
                        n_pend_mac  = i_sender_mac;
                        n_pend_ip   = i_sender_ip;
                    end else begin
                        n_pend_kind = KIND_LEARN;
                        n_pend_mac  = '0;
                        n_pend_ip   = '0;
                    end
                end else begin
                    n_strobe = 1'b1;
                    n_kind   = KIND_DROP;
                    n_mac    = '0;
                    n_ip     = '0;
                end
            end else if (i_query_ip == IP_ALL_ONES) begin
                n_strobe = 1'b1;
                n_kind   = KIND_RESOLVE;
                n_mac    = MAC_ALL_ONES;
                n_ip     = '0;
            end else if (i_query_ip == r_own_ip) begin
                n_strobe = 1'b1;
                n_kind   = KIND_RESOLVE;
                n_mac    = r_own_mac;
                n_ip     = '0;
            end else begin
                n_launch  = '{vld: 1'b1, mode: MODE_LOOKUP, done: 1'b0,
                              ip: i_query_ip, mac: '0};
                n_pend_ip = i_query_ip;
                n_state   = S_WALK;
            end
        end else if ((r_state == S_WALK) && tail.vld) begin
            case (tail.mode)
                MODE_LOOKUP: begin
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                    if (tail.done) begin
                        n_kind = KIND_RESOLVE;
                        n_mac  = tail.mac;
                        n_ip   = '0;
                    end else begin
                        n_kind = KIND_MISS;
                        n_mac  = '0;
                        n_ip   = r_pend_ip;
                    end
                end
                MODE_LEARN: begin
                    if (tail.done) begin
                        n_strobe = 1'b1;
                        n_state  = S_IDLE;
                        n_kind   = r_pend_kind;
                        n_mac    = r_pend_mac;
                        n_ip     = r_pend_ip;
                    end else begin
                        // no match and no free slot: second pass writes slot 0
                        n_launch      = tail;
                        n_launch.mode = MODE_FILL;
                    end
                end
                default: begin
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                    n_kind   = r_pend_kind;
                    n_mac    = r_pend_mac;
                    n_ip     = r_pend_ip;
                end
            endcase
        end
    end

    // control registers and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_strobe     <= 1'b0;
            r_launch.vld <= 1'b0;
            r_own_ip     <= '0;
            r_own_mac    <= '0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            r_launch <= n_launch;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_OWN_IP:  r_own_ip  <= i_cfg_data[IP_W-1:0];
                    REG_OWN_MAC: r_own_mac <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // result and pending payload
    always_ff @(posedge i_clk) begin
        r_kind      <= n_kind;
        r_mac       <= n_mac;
        r_ip        <= n_ip;
        r_pend_kind <= n_pend_kind;
        r_pend_mac  <= n_pend_mac;
        r_pend_ip   <= n_pend_ip;
    end

    assign o_result_strobe = r_strobe;
    assign o_result_kind   = r_kind;
    assign o_result_mac    = r_mac;
    assign o_result_ip     = r_ip;

`ifndef SYNTHESIS
    // a result beat never overlaps a busy item
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> !busy) else $error("result strobe while busy");

    // a bad packet is dropped in the next cycle
    a_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_cmd == CMD_PACKET) && !pkt_ok) |=>
        (o_result_strobe && (o_result_kind == KIND_DROP)))
        else $error("bad packet not dropped");

    // a token leaves the chain only during a walk
    a_tail_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tail.vld |-> (r_state == S_WALK)) else $error("stray token at chain end");

    // a launched token is only ever seen while busy
    a_launch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_launch.vld |-> busy) else $error("token launched while idle");
`endif

endmodule

>>> bench/arp_check_pkg.sv
`timescale 1ns / 1ps

package arp_check_pkg;
    import arpc_pkg::*;

    localparam logic [15:0] OP_REPLY = 16'd2;

    // one input beat as the bench sees it
    typedef struct {
        logic             cmd;
        logic [15:0]      pkt_len;
        logic [15:0]      hw_type;
        logic [15:0]      proto_type;
        logic [7:0]       hw_len;
        logic [7:0]       proto_len;
        logic [15:0]      opcode;
        logic [MAC_W-1:0] sender_mac;
        logic [IP_W-1:0]  sender_ip;
        logic [IP_W-1:0]  tgt_ip;
        logic [IP_W-1:0]  query_ip;
    } t_arp_item;

    // one result beat
    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [MAC_W-1:0]  mac;
        logic [IP_W-1:0]   ip;
    } t_arp_answer;

    class arp_resolve_ledger;
        logic [IP_W-1:0]  own_ip;
        logic [MAC_W-1:0] own_mac;
        logic [IP_W-1:0]  ip_tbl[CACHE_ENTRIES];
        logic [MAC_W-1:0] mac_tbl[CACHE_ENTRIES];
        bit               used[CACHE_ENTRIES];
        t_arp_answer      pending_answers[$];
        int unsigned      failures;

        function new();
            own_ip = '0;
            own_mac = '0;
            failures = 0;
            foreach (used[i]) begin
                used[i] = 1'b0;
                ip_tbl[i] = '0;
                mac_tbl[i] = '0;
            end
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [MAC_W-1:0] data);
            if (idx == REG_OWN_IP)
                own_ip = data[IP_W-1:0];
            else if (idx == REG_OWN_MAC)
                own_mac = data;
        endfunction

        // lowest valid slot holding this address, or -1
        function int slot_of(logic [IP_W-1:0] ip);
            for (int i = 0; i < CACHE_ENTRIES; i++)
                if (used[i] && ip_tbl[i] == ip)
                    return i;
            return -1;
        endfunction

        // update a match, else first free slot, else slot 0
        function void learn_pair(logic [IP_W-1:0] ip, logic [MAC_W-1:0] mac);
            int slot;
            slot = slot_of(ip);
            if (slot < 0) begin
                slot = 0;
                for (int i = CACHE_ENTRIES - 1; i >= 0; i--)
                    if (!used[i])
                        slot = i;
                ip_tbl[slot] = ip;
                used[slot] = 1'b1;
            end
            mac_tbl[slot] = mac;
        endfunction

        function void note_item(t_arp_item it);
            t_arp_answer a;
            int slot;
            a.kind = KIND_DROP;
            a.mac = '0;
            a.ip = '0;
            if (it.cmd == CMD_PACKET) begin
                if (it.pkt_len >= MIN_PKT_LEN && it.hw_type == HW_ETHER &&
                    it.proto_type == PROTO_IPV4 && it.hw_len == HW_ADDR_LEN &&
                    it.proto_len == IP_ADDR_LEN) begin
                    learn_pair(it.sender_ip, it.sender_mac);
                    if (it.opcode == OP_REQUEST && it.tgt_ip == own_ip) begin
                        a.kind = KIND_REPLY;
                        a.mac = it.sender_mac;
                        a.ip = it.sender_ip;
                    end else begin
                        a.kind = KIND_LEARN;
                    end
                end
            end else begin
                slot = slot_of(it.query_ip);
                if (it.query_ip == IP_ALL_ONES) begin
                    a.kind = KIND_RESOLVE;
                    a.mac = MAC_ALL_ONES;
                end else if (it.query_ip == own_ip) begin
                    a.kind = KIND_RESOLVE;
                    a.mac = own_mac;
                end else if (slot >= 0) begin
                    a.kind = KIND_RESOLVE;
                    a.mac = mac_tbl[slot];
                end else begin
                    a.kind = KIND_MISS;
                    a.ip = it.query_ip;
                end
            end
            pending_answers.push_back(a);
        endfunction

        function void check_answer(logic [KIND_W-1:0] kind, logic [MAC_W-1:0] mac,
                                   logic [IP_W-1:0] ip);
            t_arp_answer a;
            if (pending_answers.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result beat: kind %0d mac %h ip %h", kind, mac, ip);
                return;
            end
            a = pending_answers.pop_front();
            if (kind !== a.kind || mac !== a.mac || ip !== a.ip) begin
                failures++;
                if (failures <= 10)
                    $display({"result wrong: kind exp %0d got %0d, mac exp %h got %h,",
                              " ip exp %h got %h"},
                             a.kind, kind, a.mac, mac, a.ip, ip);
            end
        endfunction

        function int pending();
            return pending_answers.size();
        endfunction
    endclass

endpackage

>>> bench/arp_cache_and_responder_test.sv
`timescale 1ns / 1ps

module arp_cache_and_responder_test;
    import arpc_pkg::*;
    import arp_check_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TOP   = 8'hFF;
    localparam int POOL_SIZE = 24;
    localparam int PHASE_ITEMS = 250;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic                 i_cmd;
    logic [15:0]          i_pkt_len;
    logic [15:0]          i_hw_type;
    logic [15:0]          i_proto_type;
    logic [7:0]           i_hw_len;
    logic [7:0]           i_proto_len;
    logic [15:0]          i_opcode;
    logic [MAC_W-1:0]     i_sender_mac;
    logic [IP_W-1:0]      i_sender_ip;
    logic [IP_W-1:0]      i_tgt_ip;
    logic [IP_W-1:0]      i_query_ip;
    logic                 o_result_strobe;
    logic [KIND_W-1:0]    o_result_kind;
    logic [MAC_W-1:0]     o_result_mac;
    logic [IP_W-1:0]      o_result_ip;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [MAC_W-1:0]     i_cfg_data;

    arp_resolve_ledger ledger;
    logic [IP_W-1:0] station_ip;
    int idle_pct[4] = '{0, 63, 0, 29};

    arp_cache_and_responder dut (.*);

    // clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // result beats are taken the edge after they show
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_strobe)
            ledger.check_answer(o_result_kind, o_result_mac, o_result_ip);
    end

    function automatic logic [MAC_W-1:0] rand_mac();
        return {16'($urandom()), $urandom()};
    endfunction

    function automatic logic [IP_W-1:0] pool_ip(int idx);
        return 32'h0A00_0000 + idx;
    endfunction

    // address mix biased toward a small pool so hits and a full cache happen
    function automatic logic [IP_W-1:0] pick_ip();
        int r;
        r = $urandom_range(99);
        if (r < 70) return pool_ip($urandom_range(POOL_SIZE - 1));
        if (r < 78) return station_ip;
        if (r < 85) return IP_ALL_ONES;
        if (r < 90) return '0;
        return $urandom();
    endfunction

    function automatic t_arp_item noise_item();
        t_arp_item it;
        it.cmd = 1'($urandom_range(1));
        it.pkt_len = 16'($urandom());
        it.hw_type = 16'($urandom());
        it.proto_type = 16'($urandom());
        it.hw_len = 8'($urandom());
        it.proto_len = 8'($urandom());
        it.opcode = 16'($urandom());
        it.sender_mac = rand_mac();
        it.sender_ip = $urandom();
        it.tgt_ip = $urandom();
        it.query_ip = $urandom();
        return it;
    endfunction

    function automatic t_arp_item mk_packet(logic [15:0] len, logic [15:0] hwt,
                                            logic [15:0] prt, logic [7:0] hwl,
                                            logic [7:0] prl, logic [15:0] op,
                                            logic [MAC_W-1:0] smac, logic [IP_W-1:0] sip,
                                            logic [IP_W-1:0] tip);
        t_arp_item it;
        it = noise_item();
        it.cmd = CMD_PACKET;
        it.pkt_len = len;
        it.hw_type = hwt;
        it.proto_type = prt;
        it.hw_len = hwl;
        it.proto_len = prl;
        it.opcode = op;
        it.sender_mac = smac;
        it.sender_ip = sip;
        it.tgt_ip = tip;
        return it;
    endfunction

    function automatic t_arp_item mk_query(logic [IP_W-1:0] q);
        t_arp_item it;
        it = noise_item();
        it.cmd = CMD_RESOLVE;
        it.query_ip = q;
        return it;
    endfunction

    function automatic logic [15:0] pick_opcode();
        int r;
        r = $urandom_range(9);
        if (r < 4) return OP_REQUEST;
        if (r < 8) return OP_REPLY;
        return 16'($urandom());
    endfunction

    // mostly well-formed packets and queries, some broken or pure noise
    function automatic t_arp_item random_item();
        t_arp_item it;
        int r;
        it = noise_item();
        r = $urandom_range(99);
        if (r < 45) begin
            it.cmd = CMD_RESOLVE;
            it.query_ip = pick_ip();
        end else begin
            it = mk_packet(16'($urandom_range(65535, 28)), HW_ETHER, PROTO_IPV4,
                           HW_ADDR_LEN, IP_ADDR_LEN, pick_opcode(), rand_mac(), pick_ip(),
                           $urandom_range(1) ? station_ip : pick_ip());
            if (r >= 85) begin
                case ($urandom_range(5))
                    0: it.pkt_len = 16'($urandom_range(27));
                    1: it.hw_type = 16'($urandom());
                    2: it.proto_type = 16'($urandom());
                    3: it.hw_len = 8'($urandom());
                    4: it.proto_len = 8'($urandom());
                    default: begin
                        it = noise_item();
                        it.cmd = CMD_PACKET;
                    end
                endcase
            end
        end
        return it;
    endfunction

    // one input beat; start stays high across back-to-back beats
    task automatic send_item(input t_arp_item it, input int pct);
        int gap;
        gap = 0;
        if (pct > 0 && $urandom_range(99) < pct)
            gap = ($urandom_range(3) == 0) ? $urandom_range(40, 1) : $urandom_range(4, 1);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_cmd <= it.cmd;
        i_pkt_len <= it.pkt_len;
        i_hw_type <= it.hw_type;
        i_proto_type <= it.proto_type;
        i_hw_len <= it.hw_len;
        i_proto_len <= it.proto_len;
        i_opcode <= it.opcode;
        i_sender_mac <= it.sender_mac;
        i_sender_ip <= it.sender_ip;
        i_tgt_ip <= it.tgt_ip;
        i_query_ip <= it.query_ip;
        start <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        ledger.note_item(it);
    endtask

    // hold off until every expected result has come back
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (ledger.pending() > 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MAC_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        ledger.write_reg(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // upper data bits above the address width carry junk on purpose
    task automatic set_station(input logic [IP_W-1:0] ip, input logic [MAC_W-1:0] mac);
        write_reg(REG_OWN_IP, {16'($urandom()), ip});
        write_reg(REG_OWN_MAC, mac);
        station_ip = ip;
    endtask

    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        ledger = new();
        station_ip = '0;
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_cmd <= CMD_PACKET;
        i_pkt_len <= '0;
        i_hw_type <= '0;
        i_proto_type <= '0;
        i_hw_len <= '0;
        i_proto_len <= '0;
        i_opcode <= '0;
        i_sender_mac <= '0;
        i_sender_ip <= '0;
        i_tgt_ip <= '0;
        i_query_ip <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values: own address zero, empty cache
        send_item(mk_query('0), 0);
        send_item(mk_query(IP_ALL_ONES), 0);
        send_item(mk_query(32'h0102_0304), 0);
        send_item(mk_packet(16'd28, HW_ETHER, PROTO_IPV4, HW_ADDR_LEN, IP_ADDR_LEN,
                            OP_REQUEST, rand_mac(), 32'h0A0B_0C0D, '0), 0);
        drain();

        // spare register indexes must not touch the station
        set_station(32'hC0A8_0001, 48'h02AA_BBCC_DDEE);
        write_reg(REG_SPARE, MAC_ALL_ONES);
        write_reg(REG_TOP, MAC_ALL_ONES);
        send_item(mk_query(32'hC0A8_0001), 0);

        // learn, update, drops on each header check, other opcodes
        send_item(mk_packet(16'd28, HW_ETHER, PROTO_IPV4, HW_ADDR_LEN, IP_ADDR_LEN,
                            OP_REQUEST, MAC_ALL_ONES, 32'h0A00_0001, 32'hC0A8_0001), 0);
        send_item(mk_query(32'h0A00_0001), 0);
        send_item(mk_packet(16'hFFFF, HW_ETHER, PROTO_IPV4, HW_ADDR_LEN, IP_ADDR_LEN,
                            OP_REPLY, '0, 32'h0A00_0001, '0), 0);
        send_item(mk_query(32'h0A00_0001), 0);
        send_item(mk_packet(16'd27, HW_ETHER, PROTO_IPV4, HW_ADDR_LEN, IP_ADDR_LEN,
                            OP_REQUEST, rand_mac(), 32'h0A00_0002, 32'hC0A8_0001), 0);
        send_item(mk_packet(16'd60, 16'hFFFF, PROTO_IPV4, HW_ADDR_LEN, IP_ADDR_LEN,
                            OP_REQUEST, rand_mac(), 32'h0A00_0002, 32'hC0A8_0001), 0);
        send_item(mk_packet(16'd60, HW_ETHER, 16'h0806, HW_ADDR_LEN, IP_ADDR_LEN,
                            OP_REQUEST, rand_mac(), 32'h0A00_0002, 32'hC0A8_0001), 0);
        send_item(mk_packet(16'd60, HW_ETHER, PROTO_IPV4, 8'hFF, IP_ADDR_LEN,
                            OP_REQUEST, rand_mac(), 32'h0A00_0002, 32'hC0A8_0001), 0);
        send_item(mk_packet(16'd60, HW_ETHER, PROTO_IPV4, HW_ADDR_LEN, 8'h00,
                            OP_REQUEST, rand_mac(), 32'h0A00_0002, 32'hC0A8_0001), 0);
        send_item(mk_query(32'h0A00_0002), 0);
        // broadcast wins over a cached broadcast sender
        send_item(mk_packet(16'd46, HW_ETHER, PROTO_IPV4, HW_ADDR_LEN, IP_ADDR_LEN,
                            16'hFFFF, rand_mac(), IP_ALL_ONES, '0), 0);
        send_item(mk_query(IP_ALL_ONES), 0);
        // own address wins over a cached copy of itself
        send_item(mk_packet(16'd28, HW_ETHER, PROTO_IPV4, HW_ADDR_LEN, IP_ADDR_LEN,
                            OP_REQUEST, rand_mac(), 32'hC0A8_0001, 32'hC0A8_0002), 0);
        send_item(mk_query(32'hC0A8_0001), 0);
        send_item(mk_packet(16'd28, HW_ETHER, PROTO_IPV4, HW_ADDR_LEN, IP_ADDR_LEN,
                            OP_REQUEST, rand_mac(), '0, 32'hC0A8_0001), 0);
        send_item(mk_query('0), 0);
        send_item(mk_packet(16'd28, HW_ETHER, PROTO_IPV4, HW_ADDR_LEN, IP_ADDR_LEN,
                            16'd0, rand_mac(), 32'h0A00_0003, 32'hC0A8_0001), 0);
        send_item(mk_query(32'h7F00_0001), 0);

        // random phases, station reprogrammed between them
        for (int p = 0; p < 4; p++) begin
            drain();
            case (p)
                0: set_station(pool_ip(5), rand_mac());
                1: set_station(IP_ALL_ONES, '0);
                2: set_station('0, MAC_ALL_ONES);
                default: set_station(pool_ip(17), rand_mac());
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_item(random_item(), idle_pct[p]);
        end

        drain();
        repeat (40) @(posedge i_clk);
        if (ledger.failures == 0 && ledger.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> sim.f
hdl/arpc_pkg.sv
hdl/arpc_cell.sv
hdl/arp_cache_and_responder.sv
bench/arp_check_pkg.sv
bench/arp_cache_and_responder_test.sv
